// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/dbl_split_pkg.sv =====
// ----------------------------------------------------------------------------
// dbl_split_pkg
// Shared constants and types for the binary64 integer/fraction split.
// ----------------------------------------------------------------------------
package dbl_split_pkg;
	localparam int MantBits = 52;
	localparam logic [10:0] ExpAllOnes = 11'h7ff;
	localparam logic [10:0] ExpBias = 11'd1023;

	// fields decoded from the operand, carried into the result stage
	typedef struct packed {
		logic [63:0] x;
		logic        special;   // inf or nan
		logic        below_one; // magnitude below one
		logic        exact;     // e >= 52
		logic [5:0]  e;         // unbiased exponent, 0..51 when used
	} dec_t;
endpackage

// ===== hdl/dbl_split_dec.sv =====
// ----------------------------------------------------------------------------
// dbl_split_dec
// Classify the operand and extract its unbiased exponent.
// ----------------------------------------------------------------------------
module dbl_split_dec (
	input  logic [63:0]               x,
	output dbl_split_pkg::dec_t       dec
);
	logic [10:0] bexp;
	logic [10:0] ue;
	assign bexp = x[62:52];
	assign ue = bexp - dbl_split_pkg::ExpBias;
	always_comb begin
		dec.x = x;
		dec.special = (bexp == dbl_split_pkg::ExpAllOnes);
		dec.below_one = (bexp < dbl_split_pkg::ExpBias);
		dec.exact = !dec.below_one && (ue >= 11'(dbl_split_pkg::MantBits));
		dec.e = ue[5:0];
	end
endmodule

// ===== hdl/dbl_split_core.sv =====
// ----------------------------------------------------------------------------
// dbl_split_core
// Mask off fraction bits, normalize the remainder, build both results.
// ----------------------------------------------------------------------------
module dbl_split_core (
	input  dbl_split_pkg::dec_t dec,
	output logic [63:0]         ip,
	output logic [63:0]         fr
);
	logic [51:0] fmask, r, rn;
	logic [5:0]  lz;
	logic [63:0] sgn;
	logic [10:0] nexp;
	always_comb begin
		sgn = {dec.x[63], 63'd0};
		fmask = 52'hf_ffff_ffff_ffff >> dec.e;
		r = dec.x[51:0] & fmask;
		lz = 6'd0;
		for (int i = 0; i < 52; i++) begin
			if (r[i]) lz = 6'(51 - i);
		end
		rn = r << lz;
		// msb index p = 51-lz; exponent = bexp + p - 52
		nexp = dec.x[62:52] - 11'd1 - 11'(lz);
		if (dec.special) begin
			ip = dec.x;
			fr = (dec.x[51:0] != 52'd0) ? dec.x : sgn;
		end else if (dec.below_one) begin
			ip = (dec.x[62:0] == 63'd0) ? 64'd0 : sgn;
			fr = dec.x;
		end else if (dec.exact) begin
			ip = dec.x;
			fr = sgn;
		end else begin
			ip = {dec.x[63:52], dec.x[51:0] & ~fmask};
			fr = (r == 52'd0) ? sgn : {dec.x[63], nexp, rn[50:0], 1'b0};
		end
	end
endmodule

// ===== hdl/double_integer_fraction_split.sv =====
// ----------------------------------------------------------------------------
// double_integer_fraction_split
// Split a binary64 value into integer and fractional parts.
// ----------------------------------------------------------------------------
// channel | signals                                   | dir
// in      | valid, ready, value_bits                  | in
// out     | out_valid, out_ready, integer/fraction    | out
// One item per cycle unless out_ready stalls; input, then result register.
// Decode sits before the input register, mask/normalize before the result one.
// Reset clears valid flags only. A stalled result holds while the next item
// waits in the input stage; ready drops only when both stages are full.
module double_integer_fraction_split (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] integer_part_bits,
	output logic [63:0] fraction_bits
);
`include "assert_macros.svh"
	dbl_split_pkg::dec_t dec_c, dec_s1;
	logic        v_s1, v_s2;
	logic [63:0] ip_c, fr_c;
	logic        adv2;

	dbl_split_dec u_dec (.x(value_bits), .dec(dec_c));
	dbl_split_core u_core (.dec(dec_s1), .ip(ip_c), .fr(fr_c));

	assign adv2 = v_s1 && (!v_s2 || out_ready);
	assign ready = !v_s1 || adv2;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready) v_s1 <= valid;
			if (adv2) v_s2 <= 1'b1;
			else if (out_ready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) dec_s1 <= dec_c;
		if (adv2) begin
			integer_part_bits <= ip_c;
			fraction_bits <= fr_c;
		end
	end

	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(fraction_bits))
	`CHK_IMPL(a_ready, clk, arst_n, !ready, v_s1 && v_s2)
	`CHK_NEXT(a_fill, clk, arst_n, valid && ready, v_s1)
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives binary64 operands into the integer/fraction splitter, predicts both
// result fields per operand and compares them in arrival order, under phases
// of sender idling, receiver stalling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MantMask = 64'h000f_ffff_ffff_ffff;

	typedef struct {
		logic [63:0] ipart;
		logic [63:0] fpart;
	} split_t;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] integer_part_bits;
	logic [63:0] fraction_bits;

	logic [63:0] operand_q[$];
	split_t      split_q[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;
	bit          hold_start;
	bit          hold_done;
	bit          failed;

	double_integer_fraction_split DUT (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.value_bits(value_bits), .out_valid(out_valid), .out_ready(out_ready),
		.integer_part_bits(integer_part_bits), .fraction_bits(fraction_bits)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic split_t split_double(input logic [63:0] x);
		split_t      s;
		logic [63:0] sgn;
		logic [10:0] bexp;
		logic [63:0] fmask;
		logic [63:0] rem;
		int          e;
		int          p;
		sgn = x & SignBit;
		bexp = x[62:52];
		if (bexp == dbl_split_pkg::ExpAllOnes) begin
			s.ipart = x;
			s.fpart = (x[51:0] != 0) ? x : sgn;
		end else if (bexp < dbl_split_pkg::ExpBias) begin
			s.ipart = (x[62:0] == 0) ? 64'd0 : sgn;
			s.fpart = x;
		end else begin
			e = int'(bexp) - 1023;
			if (e >= dbl_split_pkg::MantBits) begin
				s.ipart = x;
				s.fpart = sgn;
			end else begin
				fmask = (64'd1 << (52 - e)) - 64'd1;
				rem = x & fmask;
				s.ipart = x & ~fmask;
				if (rem == 0) begin
					s.fpart = sgn;
				end else begin
					p = 0;
					for (int i = 0; i < 52; i++)
						if (rem[i]) p = i;
					s.fpart = sgn | (64'(int'(bexp) + p - 52) << 52) |
						((rem << (52 - p)) & MantMask);
				end
			end
		end
		return s;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			value_bits <= '0;
		end else if (!valid || ready) begin
			if (operand_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				valid <= 1'b1;
				value_bits <= operand_q[0];
				split_q.push_back(split_double(operand_q[0]));
				void'(operand_q.pop_front());
			end else begin
				valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (hold_start && !hold_done) begin
			out_ready <= 1'b0;
			hold_cycles <= 59;
			hold_done <= 1'b1;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		split_t want;
		if (arst_n && out_valid && out_ready) begin
			if (split_q.size() == 0) begin
				$error("result with no item pending");
				failed = 1'b1;
			end else begin
				want = split_q.pop_front();
				if (integer_part_bits !== want.ipart) begin
					$error("integer_part_bits expected %h actual %h",
						want.ipart, integer_part_bits);
					failed = 1'b1;
				end
				if (fraction_bits !== want.fpart) begin
					$error("fraction_bits expected %h actual %h",
						want.fpart, fraction_bits);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic logic [63:0] rand_operand();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2, 3: x[62:52] = 11'(1023 + $urandom_range(53));
			4: x[62:52] = 11'(1023 + $urandom_range(2));
			5: x[62:52] = 11'(1000 + $urandom_range(22));
			6: x[62:52] = ($urandom_range(1)) ? dbl_split_pkg::ExpAllOnes : 11'd0;
			7: begin
				x[62:52] = 11'(1023 + $urandom_range(51));
				x[51:0] = x[51:0] & ~((52'd1 << $urandom_range(51)) - 52'd1);
			end
			default: ;
		endcase
		return x;
	endfunction

	task automatic run_phase(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) operand_q.push_back(rand_operand());
		while (operand_q.size() > 0) @(posedge clk);
	endtask

	initial begin
		logic [63:0] directed[$];
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		directed = '{
			64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h0000_0000_0000_0001, 64'h800f_ffff_ffff_ffff,
			64'h3fef_ffff_ffff_ffff, 64'hbfe0_0000_0000_0000,
			64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0001,
			64'h3fff_ffff_ffff_ffff, 64'h4009_2000_0000_0000,
			64'hc009_21fb_5444_2d18, 64'h432f_ffff_ffff_ffff,
			64'hc32f_ffff_ffff_fffe, 64'h4330_0000_0000_0000,
			64'h4330_0000_0000_0001, 64'hc340_0000_0000_0000,
			64'h7fef_ffff_ffff_ffff, 64'h7ff0_0000_0000_0000,
			64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000,
			64'hfff0_0000_0000_0001, 64'h7fff_ffff_ffff_ffff,
			64'hffff_ffff_ffff_ffff, 64'h3fe0_0000_0000_0000
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) operand_q.push_back(directed[i]);
		while (operand_q.size() > 0) @(posedge clk);
		run_phase(250, 0, 0);
		run_phase(250, 51, 0);
		// long hold-off so the pipeline fills and back-pressures
		hold_start <= 1'b1;
		run_phase(250, 0, 51);
		run_phase(300, 11, 11);
		while (split_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dbl_split_pkg.sv
hdl/dbl_split_dec.sv
hdl/dbl_split_core.sv
hdl/double_integer_fraction_split.sv
tb/tb_top.sv
